/* rtl/core/llbp_pkg.sv */
// Shared widths, reset values and codes for the least-loaded block placer.
// No dependencies.
package llbp_pkg;

    localparam int MAX_BLOCKS_DEF = 64;
    localparam int WEIGHT_W       = 32;
    localparam int BLK_W          = 6;
    localparam int CNT_W          = 7;
    localparam int TAG_W          = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int SCAN_LIMIT     = 64;

    localparam logic [WEIGHT_W-1:0] UPPER_BOUND_RST = 32'hFFFF_FFFF;
    localparam logic [CNT_W-1:0]    BLOCK_COUNT_RST = 7'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_BOUND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_PLACE = 1'b1;

endpackage

/* rtl/core/llbp_wstore.sv */
// Block weight store: one write port, one registered read port.
// Entries never written read as zero through per-entry valid bits.
// Depends on llbp_pkg.
module llbp_wstore #(
    parameter int DEPTH = llbp_pkg::MAX_BLOCKS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  logic [llbp_pkg::WEIGHT_W-1:0] i_wdata,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    output logic [llbp_pkg::WEIGHT_W-1:0] o_rdata
);

    logic [llbp_pkg::WEIGHT_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]              r_valid;
    logic [llbp_pkg::WEIGHT_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_we) begin
            r_valid[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_valid[i_raddr] ? r_mem[i_raddr] : '0;
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/least_loaded_block_placer_core.sv */
// Least-loaded block placer: weight table, minimum scan and bound-checked move.
// Load item: written when accepted, no result. Place item: a scan of the blocks in use
// (clamped to 1..min(MAX_BLOCKS,64)), a bound check, update states if it fits, then the
// result waits in an output register; the single table read port sets the scan.
// Synchronous active-low reset clears all weights to zero and restores registers.
// Depends on llbp_pkg and llbp_wstore.
module least_loaded_block_placer_core #(
    parameter int MAX_BLOCKS = llbp_pkg::MAX_BLOCKS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_func,
    input  logic [llbp_pkg::BLK_W-1:0]     i_block_index,
    input  logic [llbp_pkg::WEIGHT_W-1:0]  i_weight,
    input  logic [llbp_pkg::TAG_W-1:0]     i_node_id,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [llbp_pkg::TAG_W-1:0]     o_node_tag,
    output logic [llbp_pkg::BLK_W-1:0]     o_new_block,
    output logic                           o_moved,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [llbp_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [llbp_pkg::WEIGHT_W-1:0]  i_cfg_data
);

    localparam int DEPTH = (MAX_BLOCKS < llbp_pkg::SCAN_LIMIT) ? MAX_BLOCKS
                                                                : llbp_pkg::SCAN_LIMIT;
    localparam int IW = $clog2(DEPTH);
    localparam logic [llbp_pkg::CNT_W-1:0] DEPTH_C = llbp_pkg::CNT_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CHECK,
        S_SUB,
        S_ADD_RD,
        S_ADD_WR,
        S_OUT
    } t_state;

    t_state                        r_state;
    logic [llbp_pkg::WEIGHT_W-1:0] r_upper_bound;
    logic [llbp_pkg::CNT_W-1:0]    r_block_count;
    logic [llbp_pkg::BLK_W-1:0]    r_idx;
    logic [llbp_pkg::WEIGHT_W-1:0] r_w;
    logic [llbp_pkg::TAG_W-1:0]    r_tag;
    logic [IW-1:0]                 r_last;
    logic [IW-1:0]                 r_cmp_idx;
    logic [IW-1:0]                 r_best;
    logic [llbp_pkg::WEIGHT_W-1:0] r_minw;
    logic                          r_out_valid;
    logic [llbp_pkg::TAG_W-1:0]    r_out_tag;
    logic [llbp_pkg::BLK_W-1:0]    r_out_block;
    logic                          r_out_moved;

    logic                          in_accept;
    logic                          idx_in_table;
    logic                          cur_in_table;
    logic [llbp_pkg::CNT_W-1:0]    scan_n;
    logic [llbp_pkg::CNT_W-1:0]    scan_last;
    logic [llbp_pkg::WEIGHT_W-1:0] add_a;
    logic [llbp_pkg::WEIGHT_W:0]   sum;
    logic                          fits;
    logic [llbp_pkg::WEIGHT_W-1:0] sat_diff;
    logic                          mem_we;
    logic [IW-1:0]                 mem_waddr;
    logic [llbp_pkg::WEIGHT_W-1:0] mem_wdata;
    logic [IW-1:0]                 mem_raddr;
    logic [llbp_pkg::WEIGHT_W-1:0] mem_rdata;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign idx_in_table = ({1'b0, i_block_index} < DEPTH_C);
    assign cur_in_table = ({1'b0, r_idx} < DEPTH_C);

    always_comb begin
        scan_n = r_block_count;
        if (scan_n == '0) begin
            scan_n = llbp_pkg::CNT_W'(1);
        end
        if (scan_n > DEPTH_C) begin
            scan_n = DEPTH_C;
        end
        scan_last = scan_n - llbp_pkg::CNT_W'(1);
    end

    // shared adder: bound check, then the add to the chosen block
    assign add_a    = (r_state == S_ADD_WR) ? mem_rdata : r_minw;
    assign sum      = {1'b0, add_a} + {1'b0, r_w};
    assign fits     = (sum <= {1'b0, r_upper_bound});
    assign sat_diff = (mem_rdata > r_w) ? (mem_rdata - r_w) : '0;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_best;
        mem_wdata = sum[llbp_pkg::WEIGHT_W-1:0];
        mem_raddr = '0;
        unique case (r_state)
            S_IDLE: begin
                mem_we    = in_accept && (i_func == llbp_pkg::FUNC_LOAD) && idx_in_table;
                mem_waddr = i_block_index[IW-1:0];
                mem_wdata = i_weight;
            end
            S_SCAN: begin
                mem_raddr = r_cmp_idx + IW'(1);
            end
            S_CHECK: begin
                mem_raddr = r_idx[IW-1:0];
            end
            S_SUB: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx[IW-1:0];
                mem_wdata = sat_diff;
            end
            S_ADD_RD: begin
                mem_raddr = r_best;
            end
            S_ADD_WR: begin
                mem_we = 1'b1;
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    llbp_wstore #(
        .DEPTH (DEPTH)
    ) u_wstore (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upper_bound <= llbp_pkg::UPPER_BOUND_RST;
            r_block_count <= llbp_pkg::BLOCK_COUNT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == llbp_pkg::CFG_UPPER_BOUND) begin
                r_upper_bound <= i_cfg_data;
            end else if (i_cfg_index == llbp_pkg::CFG_BLOCK_COUNT) begin
                r_block_count <= i_cfg_data[llbp_pkg::CNT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_accept && (i_func == llbp_pkg::FUNC_PLACE)) begin
                        r_idx     <= i_block_index;
                        r_w       <= i_weight;
                        r_tag     <= i_node_id;
                        r_last    <= scan_last[IW-1:0];
                        r_cmp_idx <= '0;
                        r_state   <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if ((r_cmp_idx == '0) || (mem_rdata < r_minw)) begin
                        r_minw <= mem_rdata;
                        r_best <= r_cmp_idx;
                    end
                    r_cmp_idx <= r_cmp_idx + IW'(1);
                    if (r_cmp_idx == r_last) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (!fits) begin
                        r_out_tag   <= r_tag;
                        r_out_block <= r_idx;
                        r_out_moved <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end else if (cur_in_table) begin
                        r_state <= S_SUB;
                    end else begin
                        r_state <= S_ADD_RD;
                    end
                end
                S_SUB: begin
                    r_state <= S_ADD_RD;
                end
                S_ADD_RD: begin
                    r_state <= S_ADD_WR;
                end
                S_ADD_WR: begin
                    r_out_tag   <= r_tag;
                    r_out_block <= llbp_pkg::BLK_W'(r_best);
                    r_out_moved <= 1'b1;
                    r_out_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_out_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_node_tag  = r_out_tag;
    assign o_new_block = r_out_block;
    assign o_moved     = r_out_moved;

endmodule

/* tb/least_loaded_block_placer_core_tb.sv */
// Self-checking testbench for least_loaded_block_placer_core: directed and random
// load/place items, with an in-bench predictor of the weight table and a scoreboard.
// Depends on llbp_pkg and the placer core RTL.
module least_loaded_block_placer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int QUIET_CYCLES = 80;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [llbp_pkg::TAG_W-1:0] tag;
        logic [llbp_pkg::BLK_W-1:0] blk;
        logic                       moved;
    } t_placement;

    class placement_scoreboard;
        logic [llbp_pkg::WEIGHT_W-1:0] weights [llbp_pkg::MAX_BLOCKS_DEF];
        logic [llbp_pkg::WEIGHT_W-1:0] bound;
        logic [llbp_pkg::CNT_W-1:0]    count;
        t_placement                    due_q[$];
        int                            errors;
        int                            loads;
        int                            places;
        int                            moves;

        function new();
            foreach (weights[j]) weights[j] = '0;
            bound  = llbp_pkg::UPPER_BOUND_RST;
            count  = llbp_pkg::BLOCK_COUNT_RST;
            errors = 0;
            loads  = 0;
            places = 0;
            moves  = 0;
        endfunction

        function void set_register(logic [llbp_pkg::CFG_IDX_W-1:0] idx,
                                   logic [llbp_pkg::WEIGHT_W-1:0] data);
            if (idx == llbp_pkg::CFG_UPPER_BOUND) bound = data;
            else if (idx == llbp_pkg::CFG_BLOCK_COUNT) count = data[llbp_pkg::CNT_W-1:0];
        endfunction

        function void note_item(logic func, logic [llbp_pkg::BLK_W-1:0] idx,
                                logic [llbp_pkg::WEIGHT_W-1:0] w,
                                logic [llbp_pkg::TAG_W-1:0] tag);
            int                            n;
            int                            lightest;
            logic [llbp_pkg::WEIGHT_W-1:0] min_w;
            logic [llbp_pkg::WEIGHT_W:0]   total;
            t_placement                    due;
            if (func == llbp_pkg::FUNC_LOAD) begin
                if (int'(idx) < llbp_pkg::MAX_BLOCKS_DEF) weights[idx] = w;
                loads++;
                return;
            end
            n = (count == 0) ? 1 : int'(count);
            if (n > llbp_pkg::MAX_BLOCKS_DEF) n = llbp_pkg::MAX_BLOCKS_DEF;
            if (n > llbp_pkg::SCAN_LIMIT) n = llbp_pkg::SCAN_LIMIT;
            lightest = 0;
            min_w = weights[0];
            for (int j = 1; j < n; j++) begin
                if (weights[j] < min_w) begin
                    min_w = weights[j];
                    lightest = j;
                end
            end
            total = {1'b0, min_w} + {1'b0, w};
            due.tag = tag;
            due.moved = (total <= {1'b0, bound});
            due.blk = due.moved ? llbp_pkg::BLK_W'(lightest) : idx;
            if (due.moved) begin
                if (int'(idx) < llbp_pkg::MAX_BLOCKS_DEF)
                    weights[idx] = (weights[idx] > w) ? weights[idx] - w : '0;
                weights[lightest] = weights[lightest] + w;
            end
            places++;
            due_q.push_back(due);
        endfunction

        function void check_result(logic [llbp_pkg::TAG_W-1:0] tag,
                                   logic [llbp_pkg::BLK_W-1:0] blk, logic moved);
            t_placement due;
            if (due_q.size() == 0) begin
                $display("%0t: unexpected result tag=%h block=%0d moved=%0b",
                         $time, tag, blk, moved);
                errors++;
                return;
            end
            due = due_q.pop_front();
            if (due.moved) moves++;
            if (tag !== due.tag) begin
                $display("%0t: node_tag expected %h actual %h", $time, due.tag, tag);
                errors++;
            end
            if (blk !== due.blk) begin
                $display("%0t: new_block expected %0d actual %0d", $time, due.blk, blk);
                errors++;
            end
            if (moved !== due.moved) begin
                $display("%0t: moved expected %0b actual %0b", $time, due.moved, moved);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_in_valid    = 1'b0;
    logic                           o_in_stall;
    logic                           i_func        = llbp_pkg::FUNC_LOAD;
    logic [llbp_pkg::BLK_W-1:0]     i_block_index = '0;
    logic [llbp_pkg::WEIGHT_W-1:0]  i_weight      = '0;
    logic [llbp_pkg::TAG_W-1:0]     i_node_id     = '0;
    logic                           o_out_valid;
    logic                           i_out_stall   = 1'b0;
    logic [llbp_pkg::TAG_W-1:0]     o_node_tag;
    logic [llbp_pkg::BLK_W-1:0]     o_new_block;
    logic                           o_moved;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [llbp_pkg::CFG_IDX_W-1:0] i_cfg_index   = llbp_pkg::CFG_UPPER_BOUND;
    logic [llbp_pkg::WEIGHT_W-1:0]  i_cfg_data    = '0;

    placement_scoreboard sb = new();
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  hold_req    = 1'b0;
    int  hold_left   = 0;
    int  cycles      = 0;

    least_loaded_block_placer_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_func        (i_func),
        .i_block_index (i_block_index),
        .i_weight      (i_weight),
        .i_node_id     (i_node_id),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_node_tag    (o_node_tag),
        .o_new_block   (o_new_block),
        .o_moved       (o_moved),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_left = HOLD_CYCLES;
            hold_req = 1'b0;
        end
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) sb.check_result(o_node_tag, o_new_block, o_moved);
            if (i_cfg_valid && o_cfg_ready) sb.set_register(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_func, i_block_index, i_weight, i_node_id);
        end
    end

    task automatic send_item(input logic func, input logic [llbp_pkg::BLK_W-1:0] idx,
                             input logic [llbp_pkg::WEIGHT_W-1:0] w,
                             input logic [llbp_pkg::TAG_W-1:0] tag);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_func        <= func;
        i_block_index <= idx;
        i_weight      <= w;
        i_node_id     <= tag;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.due_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [llbp_pkg::CFG_IDX_W-1:0] idx,
                             input logic [llbp_pkg::WEIGHT_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic configure(input logic [llbp_pkg::WEIGHT_W-1:0] bound,
                             input logic [llbp_pkg::WEIGHT_W-1:0] cnt);
        drain();
        write_reg(llbp_pkg::CFG_UPPER_BOUND, bound);
        write_reg(llbp_pkg::CFG_BLOCK_COUNT, cnt);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [llbp_pkg::WEIGHT_W-1:0] pick_weight(
        input logic [llbp_pkg::WEIGHT_W-1:0] wmax);
        int r;
        r = $urandom_range(99);
        if (r < 85) return $urandom_range(wmax);
        if (r < 95) return $urandom;
        return (r < 97) ? '0 : '1;
    endfunction

    task automatic run_random(input int count, input int unsigned wmax, input int n_scan);
        int r;
        logic [llbp_pkg::BLK_W-1:0] idx;
        for (int j = 0; j < n_scan && j < count; j++)
            send_item(llbp_pkg::FUNC_LOAD, llbp_pkg::BLK_W'(j), pick_weight(wmax), $urandom);
        for (int j = n_scan; j < count; j++) begin
            r = $urandom_range(99);
            idx = ($urandom_range(9) < 8) ? llbp_pkg::BLK_W'($urandom_range(n_scan - 1))
                                          : llbp_pkg::BLK_W'($urandom_range(63));
            if (r < 30) send_item(llbp_pkg::FUNC_LOAD, idx, pick_weight(wmax), $urandom);
            else send_item(llbp_pkg::FUNC_PLACE, idx, pick_weight(wmax), $urandom);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 16;
        rx_idle_pct = 49;
        send_item(llbp_pkg::FUNC_PLACE, 6'd0,  32'hFFFF_FFFF, 32'h0000_0000);
        send_item(llbp_pkg::FUNC_PLACE, 6'd63, 32'h0000_0001, 32'hFFFF_FFFF);
        send_item(llbp_pkg::FUNC_PLACE, 6'd1,  32'hFFFF_FFFF, 32'h0000_0001);
        send_item(llbp_pkg::FUNC_LOAD,  6'd0,  32'h0000_0000, 32'h0);
        send_item(llbp_pkg::FUNC_LOAD,  6'd63, 32'hFFFF_FFFF, 32'h0);
        send_item(llbp_pkg::FUNC_LOAD,  6'd1,  32'd5,         32'h0);
        send_item(llbp_pkg::FUNC_PLACE, 6'd1,  32'd3,         32'h0000_0002);
        send_item(llbp_pkg::FUNC_PLACE, 6'd1,  32'd10,        32'h8000_0003);
        send_item(llbp_pkg::FUNC_LOAD,  6'd0,  32'd7,         32'h0);
        send_item(llbp_pkg::FUNC_LOAD,  6'd1,  32'd7,         32'h0);
        send_item(llbp_pkg::FUNC_PLACE, 6'd1,  32'd0,         32'h5A5A_0004);
        send_item(llbp_pkg::FUNC_PLACE, 6'd42, 32'h8000_0000, 32'hA5A5_0005);
        configure(32'h0, 32'h0);
        send_item(llbp_pkg::FUNC_LOAD,  6'd0,  32'd0,         32'h0);
        send_item(llbp_pkg::FUNC_PLACE, 6'd0,  32'd0,         32'h0000_0006);
        send_item(llbp_pkg::FUNC_PLACE, 6'd2,  32'd1,         32'h0000_0007);
        configure(32'hFFFF_FFFE, 32'hFFFF_FF81);
        send_item(llbp_pkg::FUNC_PLACE, 6'd5,  32'hFFFF_FFFE, 32'h0000_0008);
        configure(32'hFFFF_FFFF, 32'd127);
        send_item(llbp_pkg::FUNC_PLACE, 6'd63, 32'h5555_5555, 32'h0000_0009);
        send_item(llbp_pkg::FUNC_PLACE, 6'd0,  32'hAAAA_AAAA, 32'h0000_000A);

        configure(32'd3000, 32'd4);
        run_random(110, 1000, 4);
        configure(32'hFFFF_FFFF, 32'd64);
        run_random(90, 32'h1000_0000, 64);

        tx_idle_pct = 49;
        rx_idle_pct = 16;
        configure(32'h0, 32'd8);
        run_random(40, 4, 8);
        configure(32'd20000, 32'd16);
        run_random(130, 3000, 16);
        configure(32'd500, 32'd1);
        run_random(50, 300, 1);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        configure($urandom, 32'd127);
        run_random(40, 50000, 64);
        configure(32'd10000, 32'd3);
        hold_req = 1'b1;
        run_random(120, 2500, 3);

        drain();
        $display("Run covered %0d load and %0d place items (%0d moved) over a spread of bounds",
                 sb.loads, sb.places, sb.moves);
        $display("and block counts; idling ran sender-heavy, receiver-heavy and off, with one "
                 , "long output hold.");
        if (sb.errors == 0 && sb.due_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches, %0d results outstanding", sb.errors, sb.due_q.size());
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
